// ===== hdl/c3zpc_pkg.sv =====
// c3zpc_pkg: shared widths, constants, register indexes and types for the
// zero-padded 3x3 convolution with clamping
// no dependencies
`default_nettype none

package c3zpc_pkg;

    // payload and arithmetic widths
    localparam int PIX_W   = 16;
    localparam int COEF_W  = 16;
    localparam int FRAC_W  = 8;
    localparam int BIAS_W  = 26;
    localparam int CROW_W  = 48;
    localparam int DIM_W   = 13;
    localparam int CNT_W   = 25;
    localparam int PROD_W  = 33;
    localparam int CSUM_W  = 35;
    localparam int ACC_W   = 38;
    localparam int TAPS    = 3;

    // configuration port
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_COEFF_TOP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_MID    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_BOTTOM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd5;

    // register reset values
    localparam logic [CROW_W-1:0] RST_COEFF_TOP    = 48'h0000_0000_0000;
    localparam logic [CROW_W-1:0] RST_COEFF_MID    = 48'h0100_0000_0000;
    localparam logic [CROW_W-1:0] RST_COEFF_BOTTOM = 48'h0000_0000_0000;
    localparam logic [BIAS_W-1:0] RST_BIAS         = '0;
    localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT = 13'd480;

    // default frame limits
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    // upper clamp bound in Q.8
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(65535 * 256);

    // one window column, index 0 = row above, 2 = row below
    typedef logic [TAPS-1:0][PIX_W-1:0]  t_col;
    typedef logic [TAPS-1:0][COEF_W-1:0] t_wcol;

    // control handed to each window cell
    typedef struct packed {
        logic            adv;    // pipeline moves
        logic            load;   // a real request enters the window
        logic            first;  // request at column zero
        logic [TAPS-1:0] mask;   // per-row tap enable for this column
    } t_cell_ctl;

    // per-stage request flags
    typedef struct packed {
        logic valid;  // stage holds a request
        logic emit;   // request produces a result
        logic last;   // result is the last of the frame
        logic clr;    // frame restarted before this request
    } t_stage;

endpackage

`default_nettype wire

// ===== hdl/c3zpc_cell.sv =====
// c3zpc_cell: one column of the 3x3 window, its three taps and column sum
// depends on c3zpc_pkg
`default_nettype none

module c3zpc_cell
    import c3zpc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_cell_ctl i_ctl,
    input  wire t_wcol     i_weight,
    input  wire t_col      i_shift_col,
    input  wire t_col      i_load_col,
    output t_col           o_col,
    output logic signed [CSUM_W-1:0] o_sum
);

    t_col                     r_col;
    logic signed [PROD_W-1:0] r_prod [TAPS];
    logic signed [PROD_W-1:0] n_prod [TAPS];
    logic signed [CSUM_W-1:0] r_sum;

    // signed weight times unsigned pixel, both widened first
    always_comb begin
        for (int i = 0; i < TAPS; i++) begin
            n_prod[i] = $signed({{(PROD_W-COEF_W){i_weight[i][COEF_W-1]}}, i_weight[i]})
                      * $signed({{(PROD_W-PIX_W){1'b0}}, i_shift_col[i]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            for (int i = 0; i < TAPS; i++) begin
                r_prod[i] <= i_ctl.mask[i] ? n_prod[i] : '0;
            end
            r_sum <= CSUM_W'(r_prod[0]) + CSUM_W'(r_prod[1]) + CSUM_W'(r_prod[2]);
        end
        if (i_ctl.load) begin
            r_col <= i_ctl.first ? i_load_col : i_shift_col;
        end
    end

    assign o_col = r_col;
    assign o_sum = r_sum;

endmodule

`default_nettype wire

// ===== hdl/c3zpc_linebuf.sv =====
// c3zpc_linebuf: line store for the two rows above, one word per column,
// registered read with a one-deep bypass of the write in flight
// depends on c3zpc_pkg
`default_nettype none

module c3zpc_linebuf
    import c3zpc_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    input  wire logic                       i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  wire logic [2*PIX_W-1:0]         i_wr_data,
    output logic [2*PIX_W-1:0]              o_rd_data
);

    logic [2*PIX_W-1:0] r_mem [DEPTH];
    logic [2*PIX_W-1:0] r_q;
    logic [2*PIX_W-1:0] r_fwd_data;
    logic               r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q        <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_q;

endmodule

`default_nettype wire

// ===== hdl/conv3x3_zero_pad_clamp.sv =====
// conv3x3_zero_pad_clamp: streaming 3x3 convolution, zero padded, clamped
// depends on c3zpc_pkg, c3zpc_linebuf, c3zpc_cell
//
// Pixels enter in raster order, one request per clock when nothing stalls,
// and the block keeps that rate: a new request is taken in the same cycle a
// finished result sits in the output register, and only a stalled output
// holds the pipeline. The result for pixel k of a frame is produced by input
// request k+W+1, so W+1 drain requests follow the W*H pixels of each frame;
// that result then passes the stage 1, product, column sum and bias sum
// registers into the output register. The two previous rows live in one
// MAX_WIDTH x 32 memory (one read and one write per clock, read-during-write
// covered by a bypass); its contents need no clearing, since edge masking
// keeps stale or unwritten entries out of every result. The window is a chain
// of three column cells shifting left on each pixel, each multiplying its column
// by three weights. Configuration must be written only while idle; nothing checks it.
`default_nettype none

module conv3x3_zero_pad_clamp
    import c3zpc_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write port
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // input request channel
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic                  i_req_type,
    input  wire logic [PIX_W-1:0]      i_pixel,
    // result channel
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [PIX_W-1:0]           o_out_pixel,
    output logic                       o_clamped,
    output logic                       o_last_of_frame,
    output logic [CNT_W-1:0]           o_clamp_total
);

    // column counter holds 0..MAX_WIDTH, row counter 0..MAX_HEIGHT+2
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 3);
    localparam int EW = (CW > DIM_W) ? CW : DIM_W;
    localparam int EH = (HW > DIM_W) ? HW : DIM_W;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [CROW_W-1:0]        r_coeff_top;
    logic [CROW_W-1:0]        r_coeff_mid;
    logic [CROW_W-1:0]        r_coeff_bottom;
    logic signed [BIAS_W-1:0] r_bias;
    logic [DIM_W-1:0]         r_frame_width;
    logic [DIM_W-1:0]         r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff_top    <= RST_COEFF_TOP;
            r_coeff_mid    <= RST_COEFF_MID;
            r_coeff_bottom <= RST_COEFF_BOTTOM;
            r_bias         <= RST_BIAS;
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_COEFF_TOP:    r_coeff_top    <= i_cfg_wdata[CROW_W-1:0];
                REG_COEFF_MID:    r_coeff_mid    <= i_cfg_wdata[CROW_W-1:0];
                REG_COEFF_BOTTOM: r_coeff_bottom <= i_cfg_wdata[CROW_W-1:0];
                REG_BIAS:         r_bias         <= $signed(i_cfg_wdata[BIAS_W-1:0]);
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata[DIM_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // effective frame size, saturated to 1..MAX
    logic [EW-1:0] fw_x;
    logic [EH-1:0] fh_x;
    logic [CW-1:0] w;
    logic [HW-1:0] h;

    always_comb begin
        fw_x = EW'(r_frame_width);
        fh_x = EH'(r_frame_height);
        priority if (fw_x == '0) begin
            w = CW'(1);
        end else if (fw_x > EW'(MAX_WIDTH)) begin
            w = CW'(MAX_WIDTH);
        end else begin
            w = CW'(fw_x);
        end
        priority if (fh_x == '0) begin
            h = HW'(1);
        end else if (fh_x > EH'(MAX_HEIGHT)) begin
            h = HW'(MAX_HEIGHT);
        end else begin
            h = HW'(fh_x);
        end
    end

    // ---------------------------------------------------------------
    // pipeline advance: everything moves unless a result waits
    // ---------------------------------------------------------------
    logic en;
    logic acc_in;
    logic r_o_valid;

    assign en      = i_rst_n && (!r_o_valid || !i_stall);
    assign o_stall = !en;
    assign acc_in  = i_valid && en;

    // ---------------------------------------------------------------
    // stage 0: input position, edge masks, line store read
    // ---------------------------------------------------------------
    logic [CW-1:0] r_in_col;
    logic [RW-1:0] r_in_row;

    logic          wrap, restart, first0, e0, emit0, last0;
    logic [CW-1:0] col1, c0;
    logic [RW-1:0] row1, r0, y0;
    logic [PIX_W-1:0] v0;
    logic [TAPS-1:0]  row_ok0, col_ok0;

    always_comb begin
        // wrap to the next row, restart past the drain tail
        wrap    = r_in_col >= w;
        col1    = wrap ? '0 : r_in_col;
        row1    = wrap ? r_in_row + RW'(1) : r_in_row;
        restart = row1 > (RW'(h) + RW'(1));
        c0      = restart ? '0 : col1;
        r0      = restart ? '0 : row1;
        first0  = (c0 == '0);

        // column zero finishes the previous row, otherwise the column to the left
        e0     = first0 ? (r0 >= RW'(2)) : (r0 != '0);
        y0     = first0 ? r0 - RW'(2) : r0 - RW'(1);
        emit0  = e0 && (y0 < RW'(h));
        last0  = first0 && emit0 && ((y0 + RW'(1)) == RW'(h));

        // rows outside the frame count as zero
        row_ok0[0] = emit0 && (y0 != '0);
        row_ok0[1] = emit0;
        row_ok0[2] = emit0 && ((y0 + RW'(1)) < RW'(h));
        // columns outside the frame count as zero
        col_ok0[0] = first0 ? (w >= CW'(2)) : (c0 >= CW'(2));
        col_ok0[1] = 1'b1;
        col_ok0[2] = !first0;

        // drain requests and padding rows write zero
        v0 = (!i_req_type && (r0 < RW'(h))) ? i_pixel : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col <= '0;
            r_in_row <= '0;
        end else if (acc_in) begin
            r_in_col <= last0 ? '0 : c0 + CW'(1);
            r_in_row <= last0 ? '0 : r0;
        end
    end

    // stage 1 registers
    t_stage           r_s1;
    logic [AW-1:0]    r_s1_addr;
    logic [PIX_W-1:0] r_s1_v;
    logic             r_s1_first;
    logic [TAPS-1:0]  r_s1_row_ok;
    logic [TAPS-1:0]  r_s1_col_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else if (en) begin
            r_s1.valid <= acc_in;
            r_s1.emit  <= acc_in && emit0;
            r_s1.last  <= last0;
            r_s1.clr   <= restart;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_addr   <= c0[AW-1:0];
            r_s1_v      <= v0;
            r_s1_first  <= first0;
            r_s1_row_ok <= row_ok0;
            r_s1_col_ok <= col_ok0;
        end
    end

    // ---------------------------------------------------------------
    // line store: word holds {row above, two rows above} per column
    // ---------------------------------------------------------------
    logic [2*PIX_W-1:0] lb_q;
    logic [PIX_W-1:0]   top1, mid1;

    assign top1 = lb_q[PIX_W-1:0];
    assign mid1 = lb_q[2*PIX_W-1:PIX_W];

    c3zpc_linebuf #(
        .DEPTH (MAX_WIDTH)
    ) u_linebuf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (en),
        .i_rd_addr (c0[AW-1:0]),
        .i_wr_en   (en && r_s1.valid),
        .i_wr_addr (r_s1_addr),
        .i_wr_data ({r_s1_v, mid1}),
        .o_rd_data (lb_q)
    );

    // ---------------------------------------------------------------
    // stage 1-3: window chain, taps and column sums
    // ---------------------------------------------------------------
    t_col                     new_col;
    t_col                     cell_col   [TAPS];
    t_col                     cell_shift [TAPS];
    t_col                     cell_load  [TAPS];
    t_wcol                    cell_wt    [TAPS];
    t_cell_ctl                cell_ctl   [TAPS];
    logic signed [CSUM_W-1:0] cell_sum   [TAPS];

    assign new_col = {r_s1_v, mid1, top1};

    for (genvar j = 0; j < TAPS; j++) begin : g_cell
        // weights of this column, left tap in the low bits of each row
        assign cell_wt[j] = {r_coeff_bottom[j*COEF_W +: COEF_W],
                             r_coeff_mid[j*COEF_W +: COEF_W],
                             r_coeff_top[j*COEF_W +: COEF_W]};

        assign cell_ctl[j].adv   = en;
        assign cell_ctl[j].load  = en && r_s1.valid;
        assign cell_ctl[j].first = r_s1_first;
        assign cell_ctl[j].mask  = r_s1_row_ok & {TAPS{r_s1_col_ok[j]}};

        if (j == TAPS - 1) begin : g_head
            // at column zero the finished row sees padding on the right
            // while the new column starts a fresh window
            assign cell_shift[j] = r_s1_first ? '0 : new_col;
            assign cell_load[j]  = new_col;
        end else begin : g_body
            assign cell_shift[j] = cell_col[j+1];
            assign cell_load[j]  = '0;
        end

        c3zpc_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (cell_ctl[j]),
            .i_weight    (cell_wt[j]),
            .i_shift_col (cell_shift[j]),
            .i_load_col  (cell_load[j]),
            .o_col       (cell_col[j]),
            .o_sum       (cell_sum[j])
        );
    end

    // request flags follow the products and column sums
    t_stage r_s2;
    t_stage r_s3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
            r_s3 <= '0;
        end else if (en) begin
            r_s2 <= r_s1;
            r_s3 <= r_s2;
        end
    end

    // ---------------------------------------------------------------
    // stage 4: bias plus the three column sums
    // ---------------------------------------------------------------
    t_stage                  r_s4;
    logic signed [ACC_W-1:0] r_s4_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4 <= '0;
        end else if (en) begin
            r_s4 <= r_s3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_acc <= ACC_W'(r_bias) + ACC_W'(cell_sum[0])
                      + ACC_W'(cell_sum[1]) + ACC_W'(cell_sum[2]);
        end
    end

    // ---------------------------------------------------------------
    // output stage: clamp, clamp count, result register
    // ---------------------------------------------------------------
    logic             sat_lo, sat_hi, clamp4;
    logic [PIX_W-1:0] px4;
    logic [CNT_W-1:0] r_cnt, cnt_base, cnt_new;

    always_comb begin
        sat_lo   = r_s4_acc[ACC_W-1];
        sat_hi   = r_s4_acc > SAT_HI;
        clamp4   = sat_lo || sat_hi;
        priority if (sat_lo) begin
            px4 = '0;
        end else if (sat_hi) begin
            px4 = '1;
        end else begin
            px4 = r_s4_acc[FRAC_W +: PIX_W];
        end
        cnt_base = r_s4.clr ? '0 : r_cnt;
        cnt_new  = cnt_base + CNT_W'(clamp4);
    end

    logic [PIX_W-1:0] r_o_pixel;
    logic             r_o_clamped;
    logic             r_o_last;
    logic [CNT_W-1:0] r_o_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_cnt     <= '0;
        end else if (en) begin
            r_o_valid <= r_s4.valid && r_s4.emit;
            if (r_s4.valid) begin
                if (r_s4.emit) begin
                    // count restarts after the last result of a frame
                    r_cnt <= r_s4.last ? '0 : cnt_new;
                end else begin
                    r_cnt <= cnt_base;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_pixel   <= px4;
            r_o_clamped <= clamp4;
            r_o_last    <= r_s4.last;
            r_o_total   <= cnt_new;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_out_pixel     = r_o_pixel;
    assign o_clamped       = r_o_clamped;
    assign o_last_of_frame = r_o_last;
    assign o_clamp_total   = r_o_total;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    // the column position never runs past the line store
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_col <= CW'(MAX_WIDTH))
        else $error("column position beyond line store depth");

    // the request that ends a frame returns the position to the origin
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_in && last0) |=> (r_in_col == '0 && r_in_row == '0))
        else $error("position not cleared after last request of frame");

    // the clamp count starts over once the last result is loaded
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_s4.valid && r_s4.emit && r_s4.last) |=> (r_cnt == '0))
        else $error("clamp count not cleared at end of frame");

    // a result only leaves with a request that produced it
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && !(r_s4.valid && r_s4.emit)) |=> !o_valid)
        else $error("result register loaded without a producing request");

endmodule

`default_nettype wire
